FILE: sv/cgi_pkg.sv
// ============================================================================
// cgi_pkg - shared types and constants for the CAM generation interval block
// Sequencer state codes, fixed-point constants and the CORDIC angle table.
// ============================================================================
`default_nettype none

package cgi_pkg;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_AMUL,
        ST_ALOAD,
        ST_ADIV,
        ST_ROT_LOAD,
        ST_ROT,
        ST_ROT_SAVE,
        ST_MSO,
        ST_MT1,
        ST_MT2,
        ST_MSA,
        ST_SUM_A,
        ST_SQ_LOAD,
        ST_SQRT,
        ST_SQ_SAVE,
        ST_VEC_LOAD,
        ST_VEC,
        ST_DMUL,
        ST_DIST,
        ST_QMUL,
        ST_QLOAD,
        ST_QDIV,
        ST_CLAMP,
        ST_OUT
    } state_t;

    // Configuration register indexes
    localparam logic [2:0] REG_DYN_EN   = 3'd0;
    localparam logic [2:0] REG_DIST_LIM = 3'd1;
    localparam logic [2:0] REG_SPD_LIM  = 3'd2;
    localparam logic [2:0] REG_HDG_LIM  = 3'd3;
    localparam logic [2:0] REG_MIN_IV   = 3'd4;
    localparam logic [2:0] REG_MAX_IV   = 3'd5;

    // Fixed-point constants (angles Q2.30 radians)
    localparam logic signed [33:0] PI_Q30     = 34'sd3373259426;
    localparam logic signed [35:0] GAIN_Q30   = 36'sd652032874;
    localparam logic signed [33:0] TWO_R_CM   = 34'sd1274200000;
    localparam logic signed [33:0] THOUSAND   = 34'sd1000;
    localparam logic [30:0]        ONE_Q30    = 31'd1073741824;
    localparam logic signed [34:0] FULL_TURN  = 35'sd3600000000;
    localparam logic signed [34:0] HALF_TURN  = 35'sd1800000000;
    localparam logic signed [31:0] LAT_MAX    = 32'sd900000000;
    localparam logic [31:0]        DIV_FULL   = 32'd3600000000;
    localparam logic [31:0]        DIV_HALF   = 32'd1800000000;
    localparam logic [11:0]        HDG_TURN   = 12'd3600;
    localparam logic [11:0]        HDG_HALF   = 12'd1800;

    // Iteration counts of the serial units
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 31;

    // atan(2^-i) in Q2.30, rounded
    function automatic logic signed [33:0] atan_step(input logic [5:0] i);
        logic signed [33:0] v;
        v = '0;
        case (i)
            6'd0:    v = 34'sd843314857;
            6'd1:    v = 34'sd497837829;
            6'd2:    v = 34'sd263043837;
            6'd3:    v = 34'sd133525159;
            6'd4:    v = 34'sd67021687;
            6'd5:    v = 34'sd33543516;
            6'd6:    v = 34'sd16775851;
            6'd7:    v = 34'sd8388437;
            6'd8:    v = 34'sd4194283;
            6'd9:    v = 34'sd2097149;
            6'd10:   v = 34'sd1048576;
            6'd11:   v = 34'sd524288;
            default: begin
                if (i <= 6'd30) begin
                    v = 34'sd1 <<< (6'd30 - i);
                end else begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/cam_generation_interval.sv
// ============================================================================
// cam_generation_interval - message generation interval from motion changes
// Haversine distance, speed and heading change against a stored reference,
// giving the next message interval and a trigger flag per timer tick.
// ============================================================================
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+---------------------------------------
//  s_      | in  | s_tvalid/s_tready | s_tdata: lat, lon, heading, speed
//  m_      | out | m_tvalid/m_tready | m_tdata: interval_ms, triggered
//  cfg_    | in  | cfg_wr_en         | cfg_index, cfg_wdata (no read-back)
//
//  A trigger with nonzero speed also needs the interval division; a disabled
//  rule skips the distance pipeline and goes straight to the answer.
//  The sequencer shares the 64-step restoring divider (used up to five times),
//  the one-step-per-cycle CORDIC (five passes) and the 31-step root.
//  aresetn is synchronous, active low; config returns to its reset values.
//  A result held by m_tready low keeps the sequencer waiting before it is
//  registered; a new tick is taken as soon as the sequencer is idle.
//
`default_nettype none

module cam_generation_interval #(
    parameter int CORDIC_STEPS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // tdata: [30:0] lat_now, [62:31] lon_now, [74:63] heading_now, [88:75] speed_now
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,
    // tdata: [15:0] interval_ms, [16] triggered
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    localparam int STEP_W = ($clog2(CORDIC_STEPS) > $clog2(cgi_pkg::DIV_STEPS)) ?
                            $clog2(CORDIC_STEPS) : $clog2(cgi_pkg::DIV_STEPS);
    localparam logic [STEP_W-1:0] CORDIC_LAST = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST    = STEP_W'(cgi_pkg::DIV_STEPS - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST   = STEP_W'(cgi_pkg::SQRT_STEPS - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    cgi_pkg::state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]  ang_idx_reg;
    logic        sq_idx_reg;
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    // configuration
    logic        dyn_en_reg;
    logic [15:0] dist_lim_reg;
    logic [13:0] spd_lim_reg;
    logic [10:0] hdg_lim_reg;
    logic [15:0] min_iv_reg;
    logic [15:0] max_iv_reg;

    // reference state
    logic signed [30:0] ref_lat_reg;
    logic signed [31:0] ref_lon_reg;
    logic [11:0] ref_hdg_reg;
    logic [13:0] ref_spd_reg;
    logic [15:0] held_iv_reg;

    // captured tick
    logic signed [30:0] lat_cap_reg;
    logic signed [31:0] lon_cap_reg;
    logic [11:0] hdg_cap_reg;
    logic [13:0] spd_cap_reg;

    // datapath
    logic signed [31:0] dlat_reg, dlon_reg, la1_reg, la2_reg;
    logic [11:0] dh_reg;
    logic [13:0] ds_reg;
    logic        neg_reg;
    logic signed [67:0] mul_reg;
    logic [63:0] dq_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic signed [35:0] cx_reg, cy_reg;
    logic signed [33:0] cz_reg;
    logic signed [33:0] sa_reg, so_reg, c1_reg, c2_reg, t_reg;
    logic [30:0] a_reg;
    logic [61:0] sv_reg, sres_reg, sbit_reg;
    logic [30:0] xs_reg, ys_reg;
    logic [31:0] dist_reg;
    logic        trig_reg;
    logic [15:0] iv_reg;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic out_free;
    logic in_xfer;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_prod;

    function automatic logic signed [31:0] clamp_lat(input logic signed [30:0] v);
        logic signed [31:0] e;
        e = 32'(v);
        if (e > cgi_pkg::LAT_MAX) begin
            e = cgi_pkg::LAT_MAX;
        end else if (e < -cgi_pkg::LAT_MAX) begin
            e = -cgi_pkg::LAT_MAX;
        end
        return e;
    endfunction

    assign out_free = !m_tvalid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    // Tick preparation: clamps, wrapped differences, heading and speed change
    logic signed [31:0] prep_la1, prep_la2, prep_dlat, prep_dlon;
    logic signed [34:0] lon_d0, lon_d1, lon_d2;
    logic [11:0] h1, h2, hdiff;
    logic [13:0] sdiff;

    always_comb begin
        prep_la1  = clamp_lat(ref_lat_reg);
        prep_la2  = clamp_lat(lat_cap_reg);
        prep_dlat = prep_la2 - prep_la1;
        lon_d0 = 35'(lon_cap_reg) - 35'(ref_lon_reg);
        // truncating remainder by a full turn
        if (lon_d0 >= cgi_pkg::FULL_TURN) begin
            lon_d1 = lon_d0 - cgi_pkg::FULL_TURN;
        end else if (lon_d0 <= -cgi_pkg::FULL_TURN) begin
            lon_d1 = lon_d0 + cgi_pkg::FULL_TURN;
        end else begin
            lon_d1 = lon_d0;
        end
        // fold into a half turn either side
        if (lon_d1 > cgi_pkg::HALF_TURN) begin
            lon_d2 = lon_d1 - cgi_pkg::FULL_TURN;
        end else if (lon_d1 < -cgi_pkg::HALF_TURN) begin
            lon_d2 = lon_d1 + cgi_pkg::FULL_TURN;
        end else begin
            lon_d2 = lon_d1;
        end
        prep_dlon = lon_d2[31:0];
        h1 = (hdg_cap_reg >= cgi_pkg::HDG_TURN) ? hdg_cap_reg - cgi_pkg::HDG_TURN
                                                : hdg_cap_reg;
        h2 = (ref_hdg_reg >= cgi_pkg::HDG_TURN) ? ref_hdg_reg - cgi_pkg::HDG_TURN
                                                : ref_hdg_reg;
        hdiff = (h1 > h2) ? h1 - h2 : h2 - h1;
        if (hdiff > cgi_pkg::HDG_HALF) begin
            hdiff = cgi_pkg::HDG_TURN - hdiff;
        end
        sdiff = (spd_cap_reg > ref_spd_reg) ? spd_cap_reg - ref_spd_reg
                                            : ref_spd_reg - spd_cap_reg;
    end

    // Angle source for the current scaling pass
    logic signed [31:0] ang_src;
    logic signed [33:0] ang_mag;

    always_comb begin
        case (ang_idx_reg)
            2'd0:    ang_src = dlat_reg;
            2'd1:    ang_src = dlon_reg;
            2'd2:    ang_src = la1_reg;
            default: ang_src = la2_reg;
        endcase
        ang_mag = ang_src[31] ? -34'(ang_src) : 34'(ang_src);
    end

    // Shared CORDIC step: rotation drives z to zero, vectoring drives y to zero
    logic cordic_sub;
    logic signed [35:0] cx_sh, cy_sh;
    logic signed [33:0] at_val;

    always_comb begin
        cordic_sub = (state_reg == cgi_pkg::ST_ROT) ? !cz_reg[33] : cy_reg[35];
        cx_sh  = cx_reg >>> step_reg;
        cy_sh  = cy_reg >>> step_reg;
        at_val = cgi_pkg::atan_step(6'(step_reg));
    end

    // Restoring divider step
    logic [32:0] div_trial;
    logic        div_ge;

    always_comb begin
        div_trial = {rem_reg, dq_reg[63]};
        div_ge    = div_trial >= {1'b0, dvs_reg};
    end

    // Square root step
    logic [61:0] sq_sum;
    logic        sq_ge;

    always_comb begin
        sq_sum = sres_reg + sbit_reg;
        sq_ge  = sv_reg >= sq_sum;
    end

    // Sum for a, distance saturation and trigger decision
    logic signed [34:0] a_sum;
    logic [30:0] a_clamped;
    logic signed [33:0] vec_z;
    logic [31:0] dist_now;
    logic        trig_now;

    always_comb begin
        a_sum = 35'(mul_reg[63:30]) + 35'(t_reg);
        if (a_sum[34]) begin
            a_clamped = '0;
        end else if (a_sum > 35'(cgi_pkg::ONE_Q30)) begin
            a_clamped = cgi_pkg::ONE_Q30;
        end else begin
            a_clamped = a_sum[30:0];
        end
        vec_z    = cz_reg[33] ? '0 : cz_reg;
        dist_now = (mul_reg[67:62] != 6'd0) ? 32'hFFFF_FFFF : mul_reg[61:30];
        trig_now = (dist_now > 32'(dist_lim_reg)) || (ds_reg > spd_lim_reg) ||
                   (dh_reg > 12'(hdg_lim_reg));
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cgi_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = dyn_en_reg ? cgi_pkg::ST_PREP : cgi_pkg::ST_OUT;
                end
            end
            cgi_pkg::ST_PREP:     state_next = cgi_pkg::ST_AMUL;
            cgi_pkg::ST_AMUL:     state_next = cgi_pkg::ST_ALOAD;
            cgi_pkg::ST_ALOAD:    state_next = cgi_pkg::ST_ADIV;
            cgi_pkg::ST_ADIV: begin
                if (step_reg == DIV_LAST) state_next = cgi_pkg::ST_ROT_LOAD;
            end
            cgi_pkg::ST_ROT_LOAD: state_next = cgi_pkg::ST_ROT;
            cgi_pkg::ST_ROT: begin
                if (step_reg == CORDIC_LAST) state_next = cgi_pkg::ST_ROT_SAVE;
            end
            cgi_pkg::ST_ROT_SAVE: begin
                state_next = (ang_idx_reg == 2'd3) ? cgi_pkg::ST_MSO : cgi_pkg::ST_AMUL;
            end
            cgi_pkg::ST_MSO:      state_next = cgi_pkg::ST_MT1;
            cgi_pkg::ST_MT1:      state_next = cgi_pkg::ST_MT2;
            cgi_pkg::ST_MT2:      state_next = cgi_pkg::ST_MSA;
            cgi_pkg::ST_MSA:      state_next = cgi_pkg::ST_SUM_A;
            cgi_pkg::ST_SUM_A:    state_next = cgi_pkg::ST_SQ_LOAD;
            cgi_pkg::ST_SQ_LOAD:  state_next = cgi_pkg::ST_SQRT;
            cgi_pkg::ST_SQRT: begin
                if (step_reg == SQRT_LAST) state_next = cgi_pkg::ST_SQ_SAVE;
            end
            cgi_pkg::ST_SQ_SAVE: begin
                state_next = sq_idx_reg ? cgi_pkg::ST_VEC_LOAD : cgi_pkg::ST_SQ_LOAD;
            end
            cgi_pkg::ST_VEC_LOAD: state_next = cgi_pkg::ST_VEC;
            cgi_pkg::ST_VEC: begin
                if (step_reg == CORDIC_LAST) state_next = cgi_pkg::ST_DMUL;
            end
            cgi_pkg::ST_DMUL:     state_next = cgi_pkg::ST_DIST;
            cgi_pkg::ST_DIST: begin
                state_next = (trig_now && spd_cap_reg != 14'd0) ? cgi_pkg::ST_QMUL
                                                                : cgi_pkg::ST_CLAMP;
            end
            cgi_pkg::ST_QMUL:     state_next = cgi_pkg::ST_QLOAD;
            cgi_pkg::ST_QLOAD:    state_next = cgi_pkg::ST_QDIV;
            cgi_pkg::ST_QDIV: begin
                if (step_reg == DIV_LAST) state_next = cgi_pkg::ST_CLAMP;
            end
            cgi_pkg::ST_CLAMP:    state_next = cgi_pkg::ST_OUT;
            cgi_pkg::ST_OUT: begin
                if (out_free) state_next = cgi_pkg::ST_IDLE;
            end
            default:              state_next = cgi_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs: handshake, step counter, multiplier operands
    // ------------------------------------------------------------------
    always_comb begin
        s_tready = (state_reg == cgi_pkg::ST_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata  = m_tdata_reg;

        step_next = '0;
        if (state_reg inside {cgi_pkg::ST_ADIV, cgi_pkg::ST_ROT, cgi_pkg::ST_SQRT,
                              cgi_pkg::ST_VEC, cgi_pkg::ST_QDIV}) begin
            if (state_next == state_reg) step_next = step_reg + 1'b1;
        end

        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            cgi_pkg::ST_AMUL: begin mul_a = ang_mag;          mul_b = cgi_pkg::PI_Q30;   end
            cgi_pkg::ST_MSO:  begin mul_a = so_reg;           mul_b = so_reg;            end
            cgi_pkg::ST_MT1:  begin mul_a = mul_reg[63:30];   mul_b = c1_reg;            end
            cgi_pkg::ST_MT2:  begin mul_a = mul_reg[63:30];   mul_b = c2_reg;            end
            cgi_pkg::ST_MSA:  begin mul_a = sa_reg;           mul_b = sa_reg;            end
            cgi_pkg::ST_DMUL: begin mul_a = vec_z;            mul_b = cgi_pkg::TWO_R_CM; end
            cgi_pkg::ST_QMUL: begin mul_a = 34'(dist_reg);    mul_b = cgi_pkg::THOUSAND; end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_prod = 68'(mul_a) * 68'(mul_b);
    end

    // ------------------------------------------------------------------
    // Control registers and configuration
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cgi_pkg::ST_IDLE;
            step_reg     <= '0;
            ang_idx_reg  <= '0;
            sq_idx_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            dyn_en_reg   <= 1'b1;
            dist_lim_reg <= 16'd400;
            spd_lim_reg  <= 14'd50;
            hdg_lim_reg  <= 11'd40;
            min_iv_reg   <= 16'd100;
            max_iv_reg   <= 16'd1000;
            ref_lat_reg  <= '0;
            ref_lon_reg  <= '0;
            ref_hdg_reg  <= '0;
            ref_spd_reg  <= '0;
            held_iv_reg  <= 16'd1000;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;

            if (state_reg == cgi_pkg::ST_PREP) begin
                ang_idx_reg <= '0;
            end else if (state_reg == cgi_pkg::ST_ROT_SAVE) begin
                ang_idx_reg <= ang_idx_reg + 1'b1;
            end

            if (state_reg == cgi_pkg::ST_SUM_A) begin
                sq_idx_reg <= 1'b0;
            end else if (state_reg == cgi_pkg::ST_SQ_SAVE) begin
                sq_idx_reg <= 1'b1;
            end

            // result register and reference update
            if (state_reg == cgi_pkg::ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
                if (dyn_en_reg) begin
                    held_iv_reg <= iv_reg;
                end
                if (trig_reg) begin
                    ref_lat_reg <= lat_cap_reg;
                    ref_lon_reg <= lon_cap_reg;
                    ref_hdg_reg <= hdg_cap_reg;
                    ref_spd_reg <= spd_cap_reg;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    cgi_pkg::REG_DYN_EN:   dyn_en_reg   <= cfg_wdata[0];
                    cgi_pkg::REG_DIST_LIM: dist_lim_reg <= cfg_wdata;
                    cgi_pkg::REG_SPD_LIM:  spd_lim_reg  <= cfg_wdata[13:0];
                    cgi_pkg::REG_HDG_LIM:  hdg_lim_reg  <= cfg_wdata[10:0];
                    cgi_pkg::REG_MIN_IV:   min_iv_reg   <= cfg_wdata;
                    cgi_pkg::REG_MAX_IV:   max_iv_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        mul_reg <= mul_prod;

        // capture the tick; a disabled rule answers with the held interval
        if (in_xfer) begin
            lat_cap_reg <= s_tdata[30:0];
            lon_cap_reg <= s_tdata[62:31];
            hdg_cap_reg <= s_tdata[74:63];
            spd_cap_reg <= s_tdata[88:75];
            iv_reg      <= held_iv_reg;
            trig_reg    <= 1'b0;
        end

        if (state_reg == cgi_pkg::ST_OUT && out_free) begin
            m_tdata_reg <= {7'd0, trig_reg, iv_reg};
        end

        unique case (state_reg)
            cgi_pkg::ST_PREP: begin
                la1_reg  <= prep_la1;
                la2_reg  <= prep_la2;
                dlat_reg <= prep_dlat;
                dlon_reg <= prep_dlon;
                dh_reg   <= hdiff;
                ds_reg   <= sdiff;
            end
            cgi_pkg::ST_AMUL: begin
                neg_reg <= ang_src[31];
            end
            cgi_pkg::ST_ALOAD: begin
                dq_reg  <= mul_reg[63:0];
                rem_reg <= '0;
                dvs_reg <= (ang_idx_reg[1]) ? cgi_pkg::DIV_HALF : cgi_pkg::DIV_FULL;
            end
            cgi_pkg::ST_ADIV, cgi_pkg::ST_QDIV: begin
                rem_reg <= div_ge ? 32'(div_trial - {1'b0, dvs_reg}) : div_trial[31:0];
                dq_reg  <= {dq_reg[62:0], div_ge};
            end
            cgi_pkg::ST_ROT_LOAD: begin
                cx_reg <= cgi_pkg::GAIN_Q30;
                cy_reg <= '0;
                cz_reg <= neg_reg ? -dq_reg[33:0] : dq_reg[33:0];
            end
            cgi_pkg::ST_ROT, cgi_pkg::ST_VEC: begin
                if (cordic_sub) begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    cz_reg <= cz_reg - at_val;
                end else begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    cz_reg <= cz_reg + at_val;
                end
            end
            cgi_pkg::ST_ROT_SAVE: begin
                case (ang_idx_reg)
                    2'd0:    sa_reg <= cy_reg[33:0];
                    2'd1:    so_reg <= cy_reg[33:0];
                    2'd2:    c1_reg <= cx_reg[33:0];
                    default: c2_reg <= cx_reg[33:0];
                endcase
            end
            cgi_pkg::ST_MSA: begin
                t_reg <= mul_reg[63:30];
            end
            cgi_pkg::ST_SUM_A: begin
                a_reg <= a_clamped;
            end
            cgi_pkg::ST_SQ_LOAD: begin
                sv_reg   <= sq_idx_reg ? (62'(cgi_pkg::ONE_Q30 - a_reg) << 30)
                                       : (62'(a_reg) << 30);
                sres_reg <= '0;
                sbit_reg <= 62'(1) << 60;
            end
            cgi_pkg::ST_SQRT: begin
                if (sq_ge) begin
                    sv_reg   <= sv_reg - sq_sum;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end else begin
                    sres_reg <= sres_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            cgi_pkg::ST_SQ_SAVE: begin
                if (sq_idx_reg) begin
                    xs_reg <= sres_reg[30:0];
                end else begin
                    ys_reg <= sres_reg[30:0];
                end
            end
            cgi_pkg::ST_VEC_LOAD: begin
                cx_reg <= 36'(xs_reg);
                cy_reg <= 36'(ys_reg);
                cz_reg <= '0;
            end
            cgi_pkg::ST_DIST: begin
                dist_reg <= dist_now;
                trig_reg <= trig_now;
            end
            cgi_pkg::ST_QLOAD: begin
                dq_reg  <= mul_reg[63:0];
                rem_reg <= '0;
                dvs_reg <= 32'(spd_cap_reg);
            end
            cgi_pkg::ST_CLAMP: begin
                if (!trig_reg || spd_cap_reg == 14'd0) begin
                    iv_reg <= max_iv_reg;
                end else if (dq_reg < 64'(min_iv_reg)) begin
                    iv_reg <= min_iv_reg;
                end else if (dq_reg > 64'(max_iv_reg)) begin
                    iv_reg <= max_iv_reg;
                end else begin
                    iv_reg <= dq_reg[15:0];
                end
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    // a finished result waits while the output register is still occupied
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cgi_pkg::ST_OUT && m_tvalid_reg && !m_tready)
        |=> (state_reg == cgi_pkg::ST_OUT))
        else $error("sequencer left output state while result register busy");

    // a disabled rule goes straight to the answer
    a_bypass: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && !dyn_en_reg) |=> (state_reg == cgi_pkg::ST_OUT && !trig_reg))
        else $error("disabled rule did not bypass the distance pipeline");

    // root of a Q30 value never exceeds one
    a_sqrt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cgi_pkg::ST_SQ_SAVE) |-> (sres_reg <= 62'(cgi_pkg::ONE_Q30)))
        else $error("square root result out of range");
`endif

endmodule

`default_nettype wire

FILE: dv/cam_generation_interval_tb.sv
// ============================================================================
// cam_generation_interval_tb - self-checking bench for the interval block
// Drives timer ticks with position, heading and speed, predicts the interval
// and trigger flag with a bit-accurate fixed-point haversine model, and
// compares every result transfer under varied idling and backpressure.
// ============================================================================
`timescale 1ns / 1ps

module cam_generation_interval_tb;

    localparam longint CYCLE_LIMIT = 4000000;
    localparam int     CORDIC_N    = 32;
    localparam longint PI_Q        = 64'sd3373259426;
    localparam longint GAIN_Q      = 64'sd652032874;
    localparam longint UNIT_Q      = 64'sd1073741824;
    localparam longint EARTH_CM    = 64'sd637100000;
    localparam longint TURN_E7     = 64'sd3600000000;
    localparam longint HALF_E7     = 64'sd1800000000;
    localparam longint POLE_E7     = 64'sd900000000;

    typedef struct packed {
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        logic [11:0]        heading;
        logic [13:0]        speed;
    } tick_t;

    typedef struct packed {
        logic [15:0] interval;
        logic        triggered;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    cam_generation_interval dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predictor copy of registers and reference state
    logic        rule_on;
    logic [15:0] dist_lim;
    logic [13:0] spd_lim;
    logic [10:0] hdg_lim;
    logic [15:0] iv_min;
    logic [15:0] iv_max;
    longint      anchor_lat, anchor_lon;
    logic [11:0] anchor_hdg;
    logic [13:0] anchor_spd;
    logic [15:0] last_interval;

    answer_t     pending_answers[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_cycles = 0;
    int          mismatches = 0;
    int          ticks_sent = 0;
    int          answers_seen = 0;
    int          triggers_seen = 0;
    longint      cycles = 0;

    // Walk state for well-formed motion
    longint      walk_lat = 0, walk_lon = 0;
    int          walk_hdg = 0, walk_spd = 0;

    function automatic longint atan_q30(input int i);
        longint head[12] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                             33543516, 16775851, 8388437, 4194283, 2097149,
                             1048576, 524288};
        if (i < 12) return head[i];
        if (i <= 30) return 64'sd1 <<< (30 - i);
        return 0;
    endfunction

    // Rotation-mode CORDIC: cosine and sine of z
    function automatic void cordic_sincos(input longint z, output longint c,
                                          output longint s);
        longint x, y, nx;
        x = GAIN_Q;
        y = 0;
        for (int i = 0; i < CORDIC_N; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= atan_q30(i);
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += atan_q30(i);
            end
            x = nx;
        end
        c = x;
        s = y;
    endfunction

    // Vectoring-mode CORDIC: atan2(y, x)
    function automatic longint cordic_angle(input longint x, input longint y);
        longint z, nx;
        z = 0;
        for (int i = 0; i < CORDIC_N; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z += atan_q30(i);
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= atan_q30(i);
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint pole_clip(input longint v);
        if (v > POLE_E7) return POLE_E7;
        if (v < -POLE_E7) return -POLE_E7;
        return v;
    endfunction

    // Sine of half an angle difference given in 1e-7 degree
    function automatic longint half_angle_sin(input longint d);
        longint r, c, s;
        r = d % TURN_E7;
        if (r > HALF_E7) r -= TURN_E7;
        else if (r < -HALF_E7) r += TURN_E7;
        cordic_sincos(r * PI_Q / TURN_E7, c, s);
        return s;
    endfunction

    function automatic longint lat_cosine(input longint lat);
        longint c, s;
        cordic_sincos(lat * PI_Q / HALF_E7, c, s);
        return c;
    endfunction

    // Great-circle distance in cm, saturated to 32 bits
    function automatic longint unsigned haversine_cm(input longint la1, input longint lo1,
                                                     input longint la2, input longint lo2);
        longint sa, so, c1, c2, a, t, z;
        longint unsigned ys, xs, d;
        la1 = pole_clip(la1);
        la2 = pole_clip(la2);
        sa = half_angle_sin(la2 - la1);
        so = half_angle_sin(lo2 - lo1);
        c1 = lat_cosine(la1);
        c2 = lat_cosine(la2);
        t = (((so * so) >>> 30) * c1) >>> 30;
        t = (t * c2) >>> 30;
        a = ((sa * sa) >>> 30) + t;
        if (a < 0) a = 0;
        if (a > UNIT_Q) a = UNIT_Q;
        ys = int_sqrt(longint'(a) << 30);
        xs = int_sqrt(longint'(UNIT_Q - a) << 30);
        z = cordic_angle(longint'(xs), longint'(ys));
        if (z < 0) z = 0;
        d = longint'(EARTH_CM * 2 * z) >> 30;
        if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
        return d;
    endfunction

    // Expected answer for one tick; updates the reference on a trigger
    function automatic answer_t predict_interval(input tick_t tk);
        answer_t ans;
        longint lat, lon;
        int h1, h2, dh, ds;
        longint unsigned span_cm, q;
        logic fire;
        logic [15:0] iv;
        lat = longint'(tk.lat);
        lon = longint'(tk.lon);
        if (!rule_on) begin
            ans.interval = last_interval;
            ans.triggered = 1'b0;
            return ans;
        end
        h1 = (tk.heading >= cgi_pkg::HDG_TURN) ? int'(tk.heading) - 3600
                                                : int'(tk.heading);
        h2 = (anchor_hdg >= cgi_pkg::HDG_TURN) ? int'(anchor_hdg) - 3600
                                                : int'(anchor_hdg);
        dh = (h1 > h2) ? h1 - h2 : h2 - h1;
        if (dh > 1800) dh = 3600 - dh;
        ds = (tk.speed > anchor_spd) ? int'(tk.speed) - int'(anchor_spd)
                                     : int'(anchor_spd) - int'(tk.speed);
        span_cm = haversine_cm(anchor_lat, anchor_lon, lat, lon);
        fire = (span_cm > dist_lim) || (ds > spd_lim) || (dh > hdg_lim);
        if (fire) begin
            if (tk.speed == 0) begin
                iv = iv_max;
            end else begin
                q = span_cm * 1000 / tk.speed;
                if (q < iv_min) iv = iv_min;
                else if (q > iv_max) iv = iv_max;
                else iv = q[15:0];
            end
            anchor_lat = lat;
            anchor_lon = lon;
            anchor_hdg = tk.heading;
            anchor_spd = tk.speed;
        end else begin
            iv = iv_max;
        end
        last_interval = iv;
        ans.interval = iv;
        ans.triggered = fire;
        return ans;
    endfunction

    function automatic void model_reset();
        rule_on = 1'b1;
        dist_lim = 16'd400;
        spd_lim = 14'd50;
        hdg_lim = 11'd40;
        iv_min = 16'd100;
        iv_max = 16'd1000;
        anchor_lat = 0;
        anchor_lon = 0;
        anchor_hdg = '0;
        anchor_spd = '0;
        last_interval = 16'd1000;
    endfunction

    // Drop valid and wait until every expected answer has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register write, only issued while the block is idle
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            cgi_pkg::REG_DYN_EN:   rule_on = val[0];
            cgi_pkg::REG_DIST_LIM: dist_lim = val;
            cgi_pkg::REG_SPD_LIM:  spd_lim = val[13:0];
            cgi_pkg::REG_HDG_LIM:  hdg_lim = val[10:0];
            cgi_pkg::REG_MIN_IV:   iv_min = val;
            cgi_pkg::REG_MAX_IV:   iv_max = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic en, input logic [15:0] dl, input logic [15:0] sl,
                             input logic [15:0] hl, input logic [15:0] mn,
                             input logic [15:0] mx);
        write_reg(cgi_pkg::REG_DYN_EN, {15'd0, en});
        write_reg(cgi_pkg::REG_DIST_LIM, dl);
        write_reg(cgi_pkg::REG_SPD_LIM, sl);
        write_reg(cgi_pkg::REG_HDG_LIM, hl);
        write_reg(cgi_pkg::REG_MIN_IV, mn);
        write_reg(cgi_pkg::REG_MAX_IV, mx);
    endtask

    // One tick transfer; valid stays high into the next call
    task automatic send_tick(input tick_t tk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 14)) @(posedge aclk);
        end
        s_tdata <= {7'd0, tk.speed, tk.heading, tk.lon, tk.lat};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_answers.push_back(predict_interval(tk));
        ticks_sent++;
    endtask

    task automatic send_fields(input longint lat, input longint lon, input int hd,
                               input int sp);
        tick_t tk;
        tk.lat = lat[30:0];
        tk.lon = lon[31:0];
        tk.heading = hd[11:0];
        tk.speed = sp[13:0];
        send_tick(tk);
    endtask

    // Mostly small moves around a walk, some legal jumps, some raw bits
    function automatic tick_t random_tick();
        tick_t tk;
        int kind;
        kind = $urandom_range(99);
        if (kind < 55) begin
            walk_lat += $signed($urandom_range(0, 1200)) - 600;
            walk_lon += $signed($urandom_range(0, 1200)) - 600;
            if (walk_lat > POLE_E7 || walk_lat < -POLE_E7) walk_lat = 0;
            if (walk_lon > HALF_E7 || walk_lon < -HALF_E7) walk_lon = 0;
            walk_hdg = (walk_hdg + $urandom_range(0, 80) + 3560) % 3600;
            walk_spd += $signed($urandom_range(0, 100)) - 50;
            if (walk_spd < 0) walk_spd = 0;
            if (walk_spd > 16383) walk_spd = 16383;
            tk.lat = walk_lat[30:0];
            tk.lon = walk_lon[31:0];
            tk.heading = walk_hdg[11:0];
            tk.speed = walk_spd[13:0];
        end else if (kind < 80) begin
            tk.lat = 31'($signed($urandom_range(0, 1800000000)) - 900000000);
            tk.lon = 32'(longint'($urandom_range(0, 3600000000)) - 1800000000);
            tk.heading = 12'($urandom_range(0, 3599));
            tk.speed = 14'($urandom_range(0, 16383));
        end else begin
            tk.lat = 31'($urandom);
            tk.lon = $urandom;
            tk.heading = 12'($urandom);
            tk.speed = 14'($urandom);
        end
        return tk;
    endfunction

    task automatic run_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        repeat (count) send_tick(random_tick());
        drain();
    endtask

    // Result handshake: random stall or long hold-off
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare every result transfer with the oldest expectation
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            answers_seen++;
            if (m_tdata[16]) triggers_seen++;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: interval %0d trig %0b",
                             m_tdata[15:0], m_tdata[16]);
            end else begin
                want = pending_answers.pop_front();
                if (m_tdata[15:0] !== want.interval || m_tdata[16] !== want.triggered) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp interval %0d trig %0b, got %0d trig %0b",
                                 want.interval, want.triggered,
                                 m_tdata[15:0], m_tdata[16]);
                end
            end
        end
    end

    // Run watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("cam_generation_interval_tb failed");
            $finish;
        end
    end

    // Boundaries and special cases at reset settings
    task automatic test_directed();
        send_fields(0, 0, 0, 0);                       // nothing moved
        send_fields(250, 0, 0, 0);                     // under distance limit
        send_fields(600, 0, 0, 1000);                  // distance and speed
        send_fields(600, 0, 0, 0);                     // speed drops to zero
        send_fields(1000000000, 0, 0, 0);              // beyond the pole
        send_fields(-1073741824, -64'sd2147483648, 0, 16383);
        send_fields(0, 1799999999, 0, 16383);
        send_fields(0, -1800000000, 0, 16383);         // date line wrap
        send_fields(0, 2147483647, 3599, 16383);
        send_fields(0, 2147483647, 0, 16383);          // heading wrap at north
        send_fields(0, 2147483647, 4095, 16383);       // out-of-range heading
        send_fields(0, 2147483647, 3600, 16383);
        send_fields(900000000, 0, 1800, 10);
        send_fields(-900000000, 0, 0, 10);             // antipodal
        send_fields(1073741823, 2147483647, 2048, 8191);
        drain();
    endtask

    // Register extremes, ignored indexes and masked values
    task automatic test_registers();
        write_reg(3'd6, 16'hFFFF);
        write_reg(3'd7, 16'h1234);
        write_all(1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd65535);
        send_fields(0, 0, 0, 0);
        send_fields(1, 0, 0, 1);
        send_fields(500000, 500000, 1000, 1);
        drain();
        write_all(1'b1, 16'd65535, 16'd0, 16'd0, 16'd5000, 16'd10);  // min above max
        send_fields(0, 0, 100, 500);
        send_fields(0, 0, 100, 500);
        send_fields(50000000, 0, 100, 1);
        drain();
        write_all(1'b0, 16'd400, 16'd50, 16'd40, 16'd1, 16'd1);       // rule off
        send_fields(123456, 654321, 900, 9000);
        send_fields(0, 0, 0, 0);
        drain();
    endtask

    task automatic test_random_phases();
        write_all(1'b1, 16'd400, 16'd50, 16'd40, 16'd100, 16'd1000);
        run_random(300, 0, 0);
        write_all(1'b1, 16'd2000, 16'd300, 16'd200, 16'd20, 16'd30000);
        run_random(300, 88, 0);
        write_all(1'b1, 16'd100, 16'd16383, 16'd1800, 16'd1, 16'd65535);
        run_random(300, 0, 88);
        write_all(1'b1, 16'd800, 16'd100, 16'd90, 16'd50, 16'd2000);
        run_random(200, 8, 8);
        write_reg(cgi_pkg::REG_DYN_EN, 16'd0);
        run_random(40, 8, 8);
        write_reg(cgi_pkg::REG_DYN_EN, 16'd1);
    endtask

    // Long receiver hold-off while ticks keep coming
    task automatic test_backpressure();
        hold_off_cycles = 3000;
        run_random(8, 0, 0);
    endtask

    initial begin
        model_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_registers();
        test_random_phases();
        test_backpressure();
        drain();
        repeat (600) @(posedge aclk);
        $display("covered %0d ticks, %0d results (%0d triggered), directed cases,",
                 ticks_sent, answers_seen, triggers_seen);
        $display("register extremes, rule off, idle/stall mixes and a long hold-off");
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("cam_generation_interval_tb passed");
        end else begin
            $display("cam_generation_interval_tb failed");
        end
        $finish;
    end

endmodule

FILE: cam_generation_interval.f
sv/cgi_pkg.sv
sv/cam_generation_interval.sv
dv/cam_generation_interval_tb.sv
